// ----- hw/rtl/tagof_pkg.sv -----
package tagof_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned SIGMA_W    = 4;
  localparam int unsigned TIDX_W     = 6;

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 4'd3;
  localparam logic               REG_SIGMA   = 1'b0;

  typedef struct packed {
    logic              last_result;
    logic              arc_flag;
    logic              gap_flag;
    logic [TIDX_W-1:0] tooth_index;
  } res_t;

  typedef struct packed {
    logic go;
    logic done;
  } eval_ctl_t;

endpackage

// ----- hw/rtl/tooth_arc_gap_outlier_flagger.sv -----
// Gear tooth arc/gap outlier flagger.
// in_*: one beat per tooth, start and end angle in tdata, tlast on the last
//   tooth of the revolution. Teeth load at one beat per cycle; beats past
//   MAX_TEETH are dropped, a dropped beat with tlast still closes the run.
// After the tlast beat in_tready stays low while the block closes the wrap
//   gap (ST_WRAP), builds the variance bounds (PREP1 to PREP3) and streams one
//   result per tooth through a 5-stage pipeline reading the arc and gap RAMs.
// Results stream one per cycle unless out_tready stalls them;
//   tlast marks the result of the last tooth, after which loading resumes.
// out_*: tooth index and flags in tdata. A stall on out_tready freezes the
//   whole read pipeline; nothing is lost or repeated.
// cfg_*: sigma_factor at addresses 0 to 3 (only paddr bit 2 is decoded); write it only between revolutions.
// Reset: sums, tooth count and state clear, sigma_factor returns to 3;
//   the RAMs need no clearing.
module tooth_arc_gap_outlier_flagger #(
  parameter int unsigned MAX_TEETH  = 64,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((2*ANGLE_BITS+7)/8)*8-1:0]    in_tdata,  // start_angle, end_angle
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata, // tooth_index, gap_flag, arc_flag
  output logic                                 out_tlast,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [tagof_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tagof_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tagof_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int unsigned A  = ANGLE_BITS;
  localparam int unsigned CW = $clog2(MAX_TEETH + 1);
  localparam int unsigned IW = $clog2(MAX_TEETH);
  localparam int unsigned SW = A + CW;
  localparam int unsigned RW = 2 * A + 3 * CW + 8;

  logic [tagof_pkg::SIGMA_W-1:0] sigma_r;
  logic                          sel_sigma;

  logic          arc_we, gap_we, rd_en;
  logic [IW-1:0] arc_waddr, gap_waddr, rd_addr;
  logic [A-1:0]  arc_wdata, gap_wdata, arc_rdata, gap_rdata;
  logic [CW-1:0] n;
  logic [SW-1:0] arc_sum, gap_sum;
  logic [RW-1:0] arc_rhs, gap_rhs;
  tagof_pkg::eval_ctl_t acc_ctl, eval_ctl;
  tagof_pkg::res_t      res;

  assign sel_sigma  = (cfg_paddr[tagof_pkg::CFG_ADDR_W-1] == tagof_pkg::REG_SIGMA);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_sigma ? tagof_pkg::CFG_DATA_W'(sigma_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= tagof_pkg::SIGMA_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_sigma) begin
      sigma_r <= cfg_pwdata[tagof_pkg::SIGMA_W-1:0];
    end
  end

  tagof_acc #(.MAX_TEETH(MAX_TEETH), .ANGLE_BITS(ANGLE_BITS)) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .start_angle (in_tdata[A-1:0]),
    .end_angle   (in_tdata[2*A-1:A]),
    .is_last     (in_tlast),
    .sigma       (sigma_r),
    .arc_we      (arc_we),
    .arc_waddr   (arc_waddr),
    .arc_wdata   (arc_wdata),
    .gap_we      (gap_we),
    .gap_waddr   (gap_waddr),
    .gap_wdata   (gap_wdata),
    .n           (n),
    .arc_sum     (arc_sum),
    .gap_sum     (gap_sum),
    .arc_rhs     (arc_rhs),
    .gap_rhs     (gap_rhs),
    .ctl_o       (acc_ctl),
    .ctl_i       (eval_ctl)
  );

  tagof_ram #(.DEPTH(MAX_TEETH), .WIDTH(ANGLE_BITS)) u_arc_ram (
    .clk   (clk),
    .we    (arc_we),
    .waddr (arc_waddr),
    .wdata (arc_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (arc_rdata)
  );

  tagof_ram #(.DEPTH(MAX_TEETH), .WIDTH(ANGLE_BITS)) u_gap_ram (
    .clk   (clk),
    .we    (gap_we),
    .waddr (gap_waddr),
    .wdata (gap_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (gap_rdata)
  );

  tagof_eval #(.MAX_TEETH(MAX_TEETH), .ANGLE_BITS(ANGLE_BITS)) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (acc_ctl),
    .ctl_o     (eval_ctl),
    .n         (n),
    .arc_sum   (arc_sum),
    .gap_sum   (gap_sum),
    .arc_rhs   (arc_rhs),
    .gap_rhs   (gap_rhs),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .arc_rdata (arc_rdata),
    .gap_rdata (gap_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.arc_flag, res.gap_flag, res.tooth_index};
  assign out_tlast = res.last_result;

endmodule

// ----- hw/rtl/tagof_ram.sv -----
module tagof_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/tagof_acc.sv -----
module tagof_acc #(
  parameter int unsigned MAX_TEETH  = 64,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ANGLE_BITS-1:0]               start_angle,
  input  logic [ANGLE_BITS-1:0]               end_angle,
  input  logic                                is_last,
  input  logic [tagof_pkg::SIGMA_W-1:0]       sigma,
  output logic                                arc_we,
  output logic [$clog2(MAX_TEETH)-1:0]        arc_waddr,
  output logic [ANGLE_BITS-1:0]               arc_wdata,
  output logic                                gap_we,
  output logic [$clog2(MAX_TEETH)-1:0]        gap_waddr,
  output logic [ANGLE_BITS-1:0]               gap_wdata,
  output logic [$clog2(MAX_TEETH+1)-1:0]      n,
  output logic [ANGLE_BITS+$clog2(MAX_TEETH+1)-1:0] arc_sum,
  output logic [ANGLE_BITS+$clog2(MAX_TEETH+1)-1:0] gap_sum,
  output logic [2*ANGLE_BITS+3*$clog2(MAX_TEETH+1)+7:0] arc_rhs,
  output logic [2*ANGLE_BITS+3*$clog2(MAX_TEETH+1)+7:0] gap_rhs,
  output tagof_pkg::eval_ctl_t                ctl_o,
  input  tagof_pkg::eval_ctl_t                ctl_i
);

  localparam int unsigned A   = ANGLE_BITS;
  localparam int unsigned CW  = $clog2(MAX_TEETH + 1);
  localparam int unsigned IW  = $clog2(MAX_TEETH);
  localparam int unsigned SW  = A + CW;
  localparam int unsigned QW  = 2 * A + CW;
  localparam int unsigned SPW = 2 * A + 2 * CW;
  localparam int unsigned KW  = 2 * tagof_pkg::SIGMA_W + CW;
  localparam int unsigned RW  = SPW + KW;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_WRAP  = 3'd1;
  localparam logic [2:0] ST_PREP1 = 3'd2;
  localparam logic [2:0] ST_PREP2 = 3'd3;
  localparam logic [2:0] ST_PREP3 = 3'd4;
  localparam logic [2:0] ST_EVAL  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic [A-1:0]  prev_end_r;
  logic [A-1:0]  first_start_r;
  logic [SW-1:0] arc_sum_r, gap_sum_r;
  logic [QW-1:0] arc_sq_r, gap_sq_r;
  logic [SPW-1:0] arc_ss_r, gap_ss_r, arc_nq_r, gap_nq_r;
  logic [SPW-1:0] arc_spread_r, gap_spread_r;
  logic [2*tagof_pkg::SIGMA_W-1:0] f2_r;
  logic [KW-1:0] k_r;
  logic [RW-1:0] arc_rhs_r, gap_rhs_r;

  logic          fire, room, wrap;
  logic [CW-1:0] cnt_m1;
  logic [2*A-1:0] arc_sq, gap_sq;

  assign in_ready = (state_r == ST_LOAD);
  assign fire     = in_valid && in_ready;
  assign room     = (cnt_r < CW'(MAX_TEETH));
  assign wrap     = (state_r == ST_WRAP);
  assign cnt_m1   = cnt_r - CW'(1);

  assign arc_we    = fire && room;
  assign arc_waddr = cnt_r[IW-1:0];
  assign arc_wdata = end_angle - start_angle;
  assign gap_we    = (fire && room && (cnt_r != '0)) || wrap;
  assign gap_waddr = cnt_m1[IW-1:0];
  assign gap_wdata = wrap ? (first_start_r - prev_end_r) : (start_angle - prev_end_r);
  assign arc_sq    = (2*A)'(arc_wdata) * (2*A)'(arc_wdata);
  assign gap_sq    = (2*A)'(gap_wdata) * (2*A)'(gap_wdata);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (fire && is_last) state_nxt = ST_WRAP;
      ST_WRAP:  state_nxt = ST_PREP1;
      ST_PREP1: state_nxt = ST_PREP2;
      ST_PREP2: state_nxt = ST_PREP3;
      ST_PREP3: state_nxt = ST_EVAL;
      ST_EVAL:  if (ctl_i.done) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      cnt_r      <= '0;
      prev_end_r <= '0;
      arc_sum_r  <= '0;
      gap_sum_r  <= '0;
      arc_sq_r   <= '0;
      gap_sq_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (arc_we) begin
        cnt_r      <= cnt_r + CW'(1);
        prev_end_r <= end_angle;
        arc_sum_r  <= arc_sum_r + SW'(arc_wdata);
        arc_sq_r   <= arc_sq_r + QW'(arc_sq);
      end
      if (gap_we) begin
        gap_sum_r <= gap_sum_r + SW'(gap_wdata);
        gap_sq_r  <= gap_sq_r + QW'(gap_sq);
      end
      if ((state_r == ST_EVAL) && ctl_i.done) begin
        cnt_r      <= '0;
        prev_end_r <= '0;
        arc_sum_r  <= '0;
        gap_sum_r  <= '0;
        arc_sq_r   <= '0;
        gap_sq_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arc_we && (cnt_r == '0)) begin
      first_start_r <= start_angle;
    end
    if (state_r == ST_PREP1) begin
      arc_ss_r <= SPW'(arc_sum_r) * SPW'(arc_sum_r);
      gap_ss_r <= SPW'(gap_sum_r) * SPW'(gap_sum_r);
      arc_nq_r <= SPW'(arc_sq_r) * SPW'(cnt_r);
      gap_nq_r <= SPW'(gap_sq_r) * SPW'(cnt_r);
      f2_r     <= (2*tagof_pkg::SIGMA_W)'(sigma) * (2*tagof_pkg::SIGMA_W)'(sigma);
    end
    if (state_r == ST_PREP2) begin
      arc_spread_r <= (arc_nq_r >= arc_ss_r) ? (arc_nq_r - arc_ss_r) : '0;
      gap_spread_r <= (gap_nq_r >= gap_ss_r) ? (gap_nq_r - gap_ss_r) : '0;
      k_r          <= KW'(f2_r) * KW'(cnt_r);
    end
    if (state_r == ST_PREP3) begin
      arc_rhs_r <= RW'(arc_spread_r) * RW'(k_r);
      gap_rhs_r <= RW'(gap_spread_r) * RW'(k_r);
    end
  end

  assign n          = cnt_r;
  assign arc_sum    = arc_sum_r;
  assign gap_sum    = gap_sum_r;
  assign arc_rhs    = arc_rhs_r;
  assign gap_rhs    = gap_rhs_r;
  assign ctl_o.go   = (state_r == ST_PREP3);
  assign ctl_o.done = 1'b0;

endmodule

// ----- hw/rtl/tagof_eval.sv -----
module tagof_eval #(
  parameter int unsigned MAX_TEETH  = 64,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tagof_pkg::eval_ctl_t                ctl_i,
  output tagof_pkg::eval_ctl_t                ctl_o,
  input  logic [$clog2(MAX_TEETH+1)-1:0]      n,
  input  logic [ANGLE_BITS+$clog2(MAX_TEETH+1)-1:0] arc_sum,
  input  logic [ANGLE_BITS+$clog2(MAX_TEETH+1)-1:0] gap_sum,
  input  logic [2*ANGLE_BITS+3*$clog2(MAX_TEETH+1)+7:0] arc_rhs,
  input  logic [2*ANGLE_BITS+3*$clog2(MAX_TEETH+1)+7:0] gap_rhs,
  output logic                                rd_en,
  output logic [$clog2(MAX_TEETH)-1:0]        rd_addr,
  input  logic [ANGLE_BITS-1:0]               arc_rdata,
  input  logic [ANGLE_BITS-1:0]               gap_rdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tagof_pkg::res_t                     res
);

  localparam int unsigned A  = ANGLE_BITS;
  localparam int unsigned CW = $clog2(MAX_TEETH + 1);
  localparam int unsigned IW = $clog2(MAX_TEETH);
  localparam int unsigned SW = A + CW;
  localparam int unsigned RW = 2 * A + 3 * CW + 8;

  logic          busy_r;
  logic [CW-1:0] issue_r;
  logic          v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [CW-1:0] i1_r, i2_r, i3_r, i4_r;
  logic [SW-1:0] arc_nx_r, gap_nx_r;
  logic [2*SW-1:0] arc_dsq_r, gap_dsq_r;
  logic [RW-1:0] arc_lhs_r, gap_lhs_r;
  tagof_pkg::res_t res_r;

  logic          adv;
  logic [CW-1:0] n_m1;
  logic [SW-1:0] arc_dev, gap_dev;

  assign adv     = !out_valid_r || out_ready;
  assign n_m1    = n - CW'(1);
  assign rd_en   = adv;
  assign rd_addr = issue_r[IW-1:0];
  assign arc_dev = (arc_nx_r >= arc_sum) ? (arc_nx_r - arc_sum) : (arc_sum - arc_nx_r);
  assign gap_dev = (gap_nx_r >= gap_sum) ? (gap_nx_r - gap_sum) : (gap_sum - gap_nx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      issue_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl_i.go) begin
        busy_r  <= 1'b1;
        issue_r <= '0;
      end else if (adv) begin
        v1_r        <= busy_r;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        v4_r        <= v3_r;
        out_valid_r <= v4_r;
        if (busy_r) begin
          issue_r <= issue_r + CW'(1);
          if (issue_r == n_m1) busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i1_r      <= issue_r;
      i2_r      <= i1_r;
      arc_nx_r  <= SW'(arc_rdata) * SW'(n);
      gap_nx_r  <= SW'(gap_rdata) * SW'(n);
      i3_r      <= i2_r;
      arc_dsq_r <= (2*SW)'(arc_dev) * (2*SW)'(arc_dev);
      gap_dsq_r <= (2*SW)'(gap_dev) * (2*SW)'(gap_dev);
      i4_r      <= i3_r;
      arc_lhs_r <= RW'(arc_dsq_r) * RW'(n_m1);
      gap_lhs_r <= RW'(gap_dsq_r) * RW'(n_m1);
      res_r.tooth_index <= tagof_pkg::TIDX_W'(i4_r);
      res_r.arc_flag    <= (arc_lhs_r > arc_rhs);
      res_r.gap_flag    <= (gap_lhs_r > gap_rhs);
      res_r.last_result <= (i4_r == n_m1);
    end
  end

  assign out_valid  = out_valid_r;
  assign res        = res_r;
  assign ctl_o.go   = 1'b0;
  assign ctl_o.done = out_valid_r && out_ready && res_r.last_result;

endmodule

// ----- dv/tooth_arc_gap_outlier_flagger_test.sv -----
`timescale 1ns / 1ps

module tooth_arc_gap_outlier_flagger_test;

  localparam int unsigned TEETH_MAX = 64;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned ITEM_GOAL = 270;

  class tooth_scoreboard;
    logic [tagof_pkg::SIGMA_W-1:0] sigma;
    logic [15:0]        start_mem[TEETH_MAX];
    logic [15:0]        arc_mem[TEETH_MAX];
    logic [15:0]        gap_mem[TEETH_MAX];
    logic [15:0]        last_end;
    int unsigned        teeth;
    longint unsigned    arc_total, arc_sq_total, gap_total, gap_sq_total;
    tagof_pkg::res_t    flags_q[$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        flagged_seen;

    function new();
      sigma = tagof_pkg::SIGMA_RESET;
      mismatches = 0;
      results_seen = 0;
      flagged_seen = 0;
      clear_revolution();
    endfunction

    function void clear_revolution();
      last_end = '0;
      teeth = 0;
      arc_total = 0;
      arc_sq_total = 0;
      gap_total = 0;
      gap_sq_total = 0;
    endfunction

    function bit deviates(longint unsigned x, longint unsigned s, longint unsigned q,
                          longint unsigned n);
      longint unsigned nx, dev, nq, ss, spread, f;
      bit [127:0] lhs, rhs;
      nx = n * x;
      dev = (nx >= s) ? nx - s : s - nx;
      nq = n * q;
      ss = s * s;
      spread = (nq >= ss) ? nq - ss : 0;
      f = 64'(sigma);
      lhs = 128'(dev * dev);
      lhs = lhs * 128'(n - 1);
      rhs = 128'(spread);
      rhs = rhs * 128'(f * f * n);
      return lhs > rhs;
    endfunction

    function void note_tooth(logic [15:0] s, logic [15:0] e, logic last);
      logic [15:0] g, a;
      tagof_pkg::res_t r;
      if (teeth < TEETH_MAX) begin
        if (teeth > 0) begin
          g = s - last_end;
          gap_mem[teeth-1] = g;
          gap_total += 64'(g);
          gap_sq_total += 64'(g) * 64'(g);
        end
        a = e - s;
        start_mem[teeth] = s;
        arc_mem[teeth] = a;
        arc_total += 64'(a);
        arc_sq_total += 64'(a) * 64'(a);
        last_end = e;
        teeth++;
      end
      if (!last) return;
      g = start_mem[0] - last_end;
      gap_mem[teeth-1] = g;
      gap_total += 64'(g);
      gap_sq_total += 64'(g) * 64'(g);
      for (int i = 0; i < teeth; i++) begin
        r = '0;
        r.tooth_index = i[tagof_pkg::TIDX_W-1:0];
        if (teeth > 1) begin
          r.gap_flag = deviates(64'(gap_mem[i]), gap_total, gap_sq_total, 64'(teeth));
          r.arc_flag = deviates(64'(arc_mem[i]), arc_total, arc_sq_total, 64'(teeth));
        end
        r.last_result = (i == teeth - 1);
        flags_q.insert(flags_q.size(), r);
      end
      clear_revolution();
    endfunction

    function void check_result(logic [7:0] d, logic l);
      tagof_pkg::res_t want, got;
      got = '0;
      got.tooth_index = d[tagof_pkg::TIDX_W-1:0];
      got.gap_flag = d[6];
      got.arc_flag = d[7];
      got.last_result = l;
      results_seen++;
      if (got.gap_flag || got.arc_flag) flagged_seen++;
      if (flags_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = flags_q.pop_front();
      if (got.tooth_index !== want.tooth_index || got.gap_flag !== want.gap_flag ||
          got.arc_flag !== want.arc_flag || got.last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // start_angle, end_angle
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;      // tooth_index, gap_flag, arc_flag
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [tagof_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [tagof_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [tagof_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  tooth_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned teeth_sent = 0;
  int unsigned revolutions = 0;
  int unsigned quiet_cycles = 0;

  tooth_arc_gap_outlier_flagger u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL tooth_arc_gap_outlier_flagger");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tooth(logic [15:0] s, logic [15:0] e, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {e, s};
    in_tlast <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_tooth(s, e, last);
    teeth_sent++;
    if (last) revolutions++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.flags_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_sigma(logic [tagof_pkg::SIGMA_W-1:0] v);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {tagof_pkg::REG_SIGMA, 2'b00};
    cfg_pwdata <= tagof_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.sigma = v;
  endtask

  // evenly pitched teeth with jitter, sometimes one bent tooth
  task automatic regular_revolution(int unsigned len);
    logic [15:0] offset, pitch, nominal, s, a;
    int unsigned odd_one, jit;
    offset = 16'($urandom);
    pitch = 16'(65536 / len);
    nominal = 16'($urandom_range(1, pitch - 1));
    odd_one = $urandom_range(len + 2);
    jit = $urandom_range(0, 40);
    for (int i = 0; i < len; i++) begin
      s = offset + 16'(i) * pitch + 16'($urandom_range(0, jit));
      a = nominal + 16'($urandom_range(0, jit));
      if (i == odd_one) begin
        if ($urandom_range(1)) a = a + 16'($urandom_range(100, 8000));
        else s = s + 16'($urandom_range(100, 8000));
      end
      send_tooth(s, s + a, i == len - 1);
    end
  endtask

  task automatic noise_revolution(int unsigned len);
    for (int i = 0; i < len; i++) send_tooth(16'($urandom), 16'($urandom), i == len - 1);
  endtask

  initial begin
    int unsigned phase_goal;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tooth(16'h0000, 16'hFFFF, 1'b1);
    for (int i = 0; i < 4; i++) send_tooth(16'(i * 16384), 16'(i * 16384 + 8192), i == 3);
    write_sigma(4'd0);
    send_tooth(16'h0000, 16'h1000, 1'b0);
    send_tooth(16'h4000, 16'h5000, 1'b0);
    send_tooth(16'h8000, 16'h9001, 1'b0);
    send_tooth(16'hC000, 16'hD000, 1'b1);
    write_sigma(4'd1);
    for (int i = 0; i < 8; i++)
      send_tooth(16'(i * 8192), 16'(i * 8192 + ((i == 5) ? 7000 : 3000)), i == 7);
    send_tooth(16'hFFFF, 16'h0000, 1'b0);
    send_tooth(16'h8000, 16'hFFFF, 1'b1);
    write_sigma(4'd15);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      phase_goal = teeth_sent + (ITEM_GOAL - 19) / 4;
      if (ph == 3) begin
        write_sigma(4'd3);
        noise_revolution(70);
      end
      while (teeth_sent < phase_goal) begin
        if ($urandom_range(3) == 0) noise_revolution($urandom_range(1, 8));
        else regular_revolution($urandom_range(2, 10));
        if ($urandom_range(4) == 0) write_sigma(tagof_pkg::SIGMA_W'($urandom_range(0, 15)));
      end
    end

    drain();
    $display("covered %0d teeth in %0d revolutions, %0d results (%0d flagged)",
             teeth_sent, revolutions, sb.results_seen, sb.flagged_seen);
    if (sb.mismatches == 0 && sb.flags_q.size() == 0) begin
      $display("PASS tooth_arc_gap_outlier_flagger");
    end else begin
      $display("FAIL tooth_arc_gap_outlier_flagger");
    end
    $finish;
  end

endmodule
